// ===== hdl/bfpd_pkg.sv =====
// bfpd_pkg: constants, codes and types for the byte frame parser dispatch block
// no dependencies; imported by byte_frame_parser_dispatch
package bfpd_pkg;

   localparam int BUFFER_DEPTH        = 32;
   localparam int NUM_SUBSCRIBERS     = 4;
   localparam int CMDS_PER_SUBSCRIBER = 4;

   localparam int ADDR_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W  = ADDR_W + 1;
   localparam int LEN_W  = 5;
   localparam int MASK_W = 4;
   localparam int FN_W   = 16;
   localparam int CSR_W  = 32;
   localparam int IDX_W  = 3;

   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(BUFFER_DEPTH - 3);

   localparam logic [7:0] HEAD_BYTE = 8'hFE;
   localparam logic [7:0] TAIL_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      STATUS_GOOD     = 2'd0,
      STATUS_BAD_SUM  = 2'd1,
      STATUS_SHORT    = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } bfpd_status_type;

   typedef enum logic [IDX_W-1:0] {
      CSR_SUB0_CMDS  = 3'd0,
      CSR_SUB1_CMDS  = 3'd1,
      CSR_SUB2_CMDS  = 3'd2,
      CSR_SUB3_CMDS  = 3'd3,
      CSR_SUB_ENABLE = 3'd4
   } bfpd_csr_type;

   typedef enum logic [1:0] {
      ST_HUNT,
      ST_FRAME,
      ST_DRAIN_RD,
      ST_DRAIN_LD
   } bfpd_state_type;

   // one bit per enabled subscriber that lists cmd among its command bytes
   function automatic logic [MASK_W-1:0] match_cmds(
      input logic [NUM_SUBSCRIBERS*CSR_W-1:0] cmds,
      input logic [MASK_W-1:0]                enable,
      input logic [7:0]                       cmd
   );
      logic [MASK_W-1:0] mask;
      mask = '0;
      for (int s = 0; s < NUM_SUBSCRIBERS; s++) begin
         for (int j = 0; j < CMDS_PER_SUBSCRIBER; j++) begin
            if (enable[s] && cmds[s*CSR_W + 8*j +: 8] == cmd) begin
               mask[s] = 1'b1;
            end
         end
      end
      return mask;
   endfunction

endpackage

// ===== hdl/bfpd_ram.sv =====
// bfpd_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies
module bfpd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/byte_frame_parser_dispatch.sv =====
// byte_frame_parser_dispatch: frame deframer with additive checksum and subscriber match
// depends on bfpd_pkg and bfpd_ram (frame store)
//
//   channel  dir  ports                         contents
//   req      in   req_tvalid/tready/tdata       one received byte
//   rsp      out  rsp_tvalid/tready/tdata/tuser payload byte or frame status, tlast ends frame
//   csr      in   csr_we/index/wdata            subscriber command lists and enable
//
// bytes are taken while hunting or in a frame; the tail byte of a bad, short, overflowed
// or empty frame yields its single result. a good frame with payload drains one result
// per byte, by a registered read of the frame store (ST_DRAIN_RD) and a load (ST_DRAIN_LD);
// no byte is taken while it drains. bytes past the filled part of the store read as zero,
// so no clearing pass is needed. reset is synchronous; rsp backpressure stalls req.
module byte_frame_parser_dispatch
   import bfpd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // rx_byte
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,   // cmd_code, payload_len, payload_byte, byte_index,
                                         // match_mask, frame_number, zero pad
   output logic [1:0]       rsp_tuser,   // status
   output logic             rsp_tlast,
   input  logic             csr_we,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0] csr_wdata
);

   bfpd_state_type state_ff, state_in;

   logic [NUM_SUBSCRIBERS*CSR_W-1:0] sub_cmds_ff;
   logic [MASK_W-1:0]                sub_enable_ff;

   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        sum_ff, sum_in;
   logic [7:0]        last_ff, last_in;
   logic [7:0]        cmd_ff, cmd_in;
   logic [7:0]        len_raw_ff, len_raw_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [FN_W-1:0]   frames_ff, frames_in;

   logic              rsp_valid_ff, rsp_valid_in;
   bfpd_status_type   rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_cmd_ff, rsp_cmd_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [7:0]        rsp_pb_ff, rsp_pb_in;
   logic [LEN_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic [FN_W-1:0]   rsp_fn_ff, rsp_fn_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              out_free;
   logic              req_fire;
   logic              is_tail;
   logic              tail_fire;
   logic              drain_go;
   logic              drain_last;
   logic [LEN_W-1:0]  len_sat;
   bfpd_status_type   judge;
   logic [MASK_W-1:0] match_c;
   logic [CNT_W-1:0]  rd_pos;
   logic              ram_we;
   logic              ram_re;
   logic [7:0]        ram_rd_data;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_HUNT || state_ff == ST_FRAME) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign is_tail    = (state_ff == ST_FRAME) && (req_tdata == TAIL_BYTE);
   assign tail_fire  = req_fire && is_tail;
   assign ram_we     = req_fire && (state_ff == ST_FRAME) && !is_tail
                       && (fill_ff < CNT_W'(BUFFER_DEPTH));
   assign ram_re     = (state_ff == ST_DRAIN_RD);
   assign rd_pos     = CNT_W'(idx_ff) + CNT_W'(2);
   assign drain_go   = (state_ff == ST_DRAIN_LD) && out_free;
   assign drain_last = (idx_ff + LEN_W'(1)) == len_ff;

   assign len_sat = (len_raw_ff > 8'(LEN_CAP)) ? LEN_CAP : len_raw_ff[LEN_W-1:0];
   assign match_c = match_cmds(sub_cmds_ff, sub_enable_ff, cmd_ff);

   // sum_ff holds all stored bytes but the newest, which is the checksum candidate
   always_comb begin
      if (ovf_ff) begin
         judge = STATUS_OVERFLOW;
      end else if (fill_ff < CNT_W'(3)) begin
         judge = STATUS_SHORT;
      end else if (sum_ff != last_ff) begin
         judge = STATUS_BAD_SUM;
      end else begin
         judge = STATUS_GOOD;
      end
   end

   bfpd_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[ADDR_W-1:0]),
      .wr_data (req_tdata),
      .rd_en   (ram_re),
      .rd_addr (rd_pos[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HUNT: begin
            if (req_fire && req_tdata == HEAD_BYTE) begin
               state_in = ST_FRAME;
            end
         end
         ST_FRAME: begin
            if (tail_fire) begin
               if (judge == STATUS_GOOD && len_sat != '0) begin
                  state_in = ST_DRAIN_RD;
               end else begin
                  state_in = ST_HUNT;
               end
            end
         end
         ST_DRAIN_RD: begin
            state_in = ST_DRAIN_LD;
         end
         ST_DRAIN_LD: begin
            if (drain_go) begin
               state_in = drain_last ? ST_HUNT : ST_DRAIN_RD;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   // datapath and result register
   always_comb begin
      fill_in    = fill_ff;
      ovf_in     = ovf_ff;
      sum_in     = sum_ff;
      last_in    = last_ff;
      cmd_in     = cmd_ff;
      len_raw_in = len_raw_ff;
      len_in     = len_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      frames_in  = frames_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_pb_in     = rsp_pb_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_fn_in     = rsp_fn_ff;
      rsp_last_in   = rsp_last_ff;

      if (ram_we) begin
         fill_in = fill_ff + CNT_W'(1);
         last_in = req_tdata;
         if (fill_ff != '0) begin
            sum_in = sum_ff + last_ff;
         end
         if (fill_ff == CNT_W'(0)) begin
            cmd_in = req_tdata;
         end
         if (fill_ff == CNT_W'(1)) begin
            len_raw_in = req_tdata;
         end
      end else if (req_fire && state_ff == ST_FRAME && !is_tail) begin
         ovf_in = 1'b1;
      end

      if (tail_fire) begin
         len_in  = len_sat;
         mask_in = match_c;
         idx_in  = '0;
         if (!(judge == STATUS_GOOD && len_sat != '0)) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = judge;
            rsp_cmd_in    = cmd_ff;
            rsp_len_in    = len_sat;
            rsp_pb_in     = '0;
            rsp_idx_in    = '0;
            rsp_mask_in   = (judge == STATUS_GOOD) ? match_c : '0;
            rsp_fn_in     = frames_ff;
            rsp_last_in   = 1'b1;
            if (judge == STATUS_GOOD) begin
               frames_in = frames_ff + FN_W'(1);
            end
         end
      end

      if (drain_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_GOOD;
         rsp_cmd_in    = cmd_ff;
         rsp_len_in    = len_ff;
         // bytes past the received ones belong to an older frame and read as zero
         rsp_pb_in     = (rd_pos < fill_ff) ? ram_rd_data : 8'd0;
         rsp_idx_in    = idx_ff;
         rsp_mask_in   = mask_ff;
         rsp_fn_in     = frames_ff;
         rsp_last_in   = drain_last;
         idx_in        = idx_ff + LEN_W'(1);
         if (drain_last) begin
            frames_in = frames_ff + FN_W'(1);
         end
      end

      // frame done: drop everything collected
      if ((tail_fire && !(judge == STATUS_GOOD && len_sat != '0)) || (drain_go && drain_last)) begin
         fill_in    = '0;
         ovf_in     = 1'b0;
         sum_in     = '0;
         last_in    = '0;
         cmd_in     = '0;
         len_raw_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_HUNT;
         sub_cmds_ff   <= '0;
         sub_enable_ff <= '0;
         fill_ff       <= '0;
         ovf_ff        <= 1'b0;
         sum_ff        <= '0;
         last_ff       <= '0;
         cmd_ff        <= '0;
         len_raw_ff    <= '0;
         idx_ff        <= '0;
         frames_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         ovf_ff       <= ovf_in;
         sum_ff       <= sum_in;
         last_ff      <= last_in;
         cmd_ff       <= cmd_in;
         len_raw_ff   <= len_raw_in;
         idx_ff       <= idx_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SUB0_CMDS:  sub_cmds_ff[0*CSR_W +: CSR_W] <= csr_wdata;
               CSR_SUB1_CMDS:  sub_cmds_ff[1*CSR_W +: CSR_W] <= csr_wdata;
               CSR_SUB2_CMDS:  sub_cmds_ff[2*CSR_W +: CSR_W] <= csr_wdata;
               CSR_SUB3_CMDS:  sub_cmds_ff[3*CSR_W +: CSR_W] <= csr_wdata;
               CSR_SUB_ENABLE: sub_enable_ff <= csr_wdata[MASK_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff        <= len_in;
      mask_ff       <= mask_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_pb_ff     <= rsp_pb_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_fn_ff     <= rsp_fn_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_fn_ff, rsp_mask_ff, rsp_idx_ff, rsp_pb_ff,
                        rsp_len_ff, rsp_cmd_ff};

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(BUFFER_DEPTH))
      else $error("frame store fill count beyond depth");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (fill_ff == CNT_W'(BUFFER_DEPTH)))
      else $error("overflow flagged while store not full");

   a_drain_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN_RD || state_ff == ST_DRAIN_LD) |-> (idx_ff < len_ff))
      else $error("drain index past saturated length");

   a_frames_step: assert property (@(posedge clock) disable iff (reset)
      (frames_ff != $past(frames_ff)) |-> (rsp_valid_ff && rsp_last_ff
                                           && rsp_status_ff == STATUS_GOOD))
      else $error("good frame count moved without a final good result");
`endif

endmodule
